>>> design/bdc_pkg.sv
// Shared types and constants for the Bernstein dependency checker.
// No dependencies; imported by bdc_cell, bernstein_dependency_checker and the testbench files.
`default_nettype none

package bdc_pkg;

    localparam int VAR_COUNT          = 26;   // variables A .. Z
    localparam int WVAR_W             = 5;
    localparam int POS_W              = 4;
    localparam int MASK_W             = 16;
    localparam int DEF_MAX_STATEMENTS = 16;

    // Statement word as it travels down the cell chain.
    typedef struct packed {
        logic                 ovf;
        logic [VAR_COUNT-1:0] rset;
        logic [WVAR_W-1:0]    wvar;
    } t_stmt;

endpackage

`default_nettype wire

>>> design/bdc_cell.sv
// One table entry of the checker chain: holds one stored statement and
// compares each passing statement word against it. Depends on bdc_pkg.
`default_nettype none

module bdc_cell #(
    parameter int MAX_STATEMENTS = bdc_pkg::DEF_MAX_STATEMENTS,
    parameter int IDX            = 0,
    parameter int IDX_W          = $clog2(MAX_STATEMENTS)
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    // word from the upstream neighbor
    input  wire                      i_valid,
    input  wire bdc_pkg::t_stmt      i_stmt,
    input  wire [IDX_W-1:0]          i_pos,
    input  wire [MAX_STATEMENTS-1:0] i_flow,
    input  wire [MAX_STATEMENTS-1:0] i_anti,
    input  wire [MAX_STATEMENTS-1:0] i_outd,
    input  wire [MAX_STATEMENTS-1:0] i_par,
    output logic                     o_move,
    // word to the downstream neighbor
    input  wire                      i_down_move,
    output logic                     o_valid,
    output bdc_pkg::t_stmt           o_stmt,
    output logic [IDX_W-1:0]         o_pos,
    output logic [MAX_STATEMENTS-1:0] o_flow,
    output logic [MAX_STATEMENTS-1:0] o_anti,
    output logic [MAX_STATEMENTS-1:0] o_outd,
    output logic [MAX_STATEMENTS-1:0] o_par
);
    import bdc_pkg::*;

    localparam logic [IDX_W-1:0] MY_POS = IDX_W'(IDX);

    logic                      r_valid;
    t_stmt                     r_stmt;
    logic [IDX_W-1:0]          r_pos;
    logic [MAX_STATEMENTS-1:0] r_flow, r_anti, r_outd, r_par;
    logic [VAR_COUNT-1:0]      r_entry_rset;
    logic [WVAR_W-1:0]         r_entry_wvar;

    logic                      live, f, a, o, store;
    logic [MAX_STATEMENTS-1:0] n_flow, n_anti, n_outd, n_par;

    // Advance when this slot is empty or its word moves on.
    assign o_move = !r_valid || i_down_move;

    always_comb begin
        live  = i_valid && !i_stmt.ovf && (i_pos > MY_POS);
        f     = live && (32'(r_entry_wvar) < VAR_COUNT)
                && ((i_stmt.rset >> r_entry_wvar) & VAR_COUNT'(1)) != '0;
        a     = live && (32'(i_stmt.wvar) < VAR_COUNT)
                && ((r_entry_rset >> i_stmt.wvar) & VAR_COUNT'(1)) != '0;
        o     = live && (r_entry_wvar == i_stmt.wvar);
        store = o_move && i_valid && !i_stmt.ovf && (i_pos == MY_POS);
        n_flow      = i_flow;
        n_anti      = i_anti;
        n_outd      = i_outd;
        n_par       = i_par;
        n_flow[IDX] = f;
        n_anti[IDX] = a;
        n_outd[IDX] = o;
        n_par[IDX]  = live && !f && !a && !o;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_move) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_move) begin
            r_stmt <= i_stmt;
            r_pos  <= i_pos;
            r_flow <= n_flow;
            r_anti <= n_anti;
            r_outd <= n_outd;
            r_par  <= n_par;
        end
        if (store) begin
            r_entry_rset <= i_stmt.rset;
            r_entry_wvar <= i_stmt.wvar;
        end
    end

    assign o_valid = r_valid;
    assign o_stmt  = r_stmt;
    assign o_pos   = r_pos;
    assign o_flow  = r_flow;
    assign o_anti  = r_anti;
    assign o_outd  = r_outd;
    assign o_par   = r_par;

endmodule

`default_nettype wire

>>> design/bernstein_dependency_checker.sv
// Top level of the Bernstein dependency checker: position counter and a
// chain of bdc_cell entries. Depends on bdc_pkg and bdc_cell.
//
//   channel   valid         ready         payload
//   input     i_in_valid    o_in_ready    i_new_program, i_read_set, i_write_var
//   output    o_out_valid   i_out_ready   o_stmt_position, o_*_deps, o_parallel_with,
//                                         o_overflow
//
// A word walks the chain one cell per cycle while the cell ahead can take it,
// and its result is read from the last cell. A new word may enter every cycle
// while the first cell can advance. Each cell compares against its own entry and
// the word is stored at the cell of its position. Reset clears the chain and the
// position counter, not the stored entries. An output stall backs up through the
// chain; bubbles still close up, so input is taken until every cell holds a word.
`default_nettype none

module bernstein_dependency_checker #(
    parameter int MAX_STATEMENTS = bdc_pkg::DEF_MAX_STATEMENTS
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire                          i_new_program,
    input  wire [bdc_pkg::VAR_COUNT-1:0] i_read_set,
    input  wire [bdc_pkg::WVAR_W-1:0]    i_write_var,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [bdc_pkg::POS_W-1:0]    o_stmt_position,
    output logic [bdc_pkg::MASK_W-1:0]   o_flow_deps,
    output logic [bdc_pkg::MASK_W-1:0]   o_anti_deps,
    output logic [bdc_pkg::MASK_W-1:0]   o_output_deps,
    output logic [bdc_pkg::MASK_W-1:0]   o_parallel_with,
    output logic                         o_overflow
);
    import bdc_pkg::*;

    localparam int IDX_W = $clog2(MAX_STATEMENTS);
    localparam int CNT_W = $clog2(MAX_STATEMENTS + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_STATEMENTS);

    logic [CNT_W-1:0] r_count, n_count, base;
    logic             accept, full;
    t_stmt            in_stmt;
    logic [IDX_W-1:0] in_pos;

    logic                      w_valid [MAX_STATEMENTS+1];
    t_stmt                     w_stmt  [MAX_STATEMENTS+1];
    logic [IDX_W-1:0]          w_pos   [MAX_STATEMENTS+1];
    logic [MAX_STATEMENTS-1:0] w_flow  [MAX_STATEMENTS+1];
    logic [MAX_STATEMENTS-1:0] w_anti  [MAX_STATEMENTS+1];
    logic [MAX_STATEMENTS-1:0] w_outd  [MAX_STATEMENTS+1];
    logic [MAX_STATEMENTS-1:0] w_par   [MAX_STATEMENTS+1];
    logic                      w_move  [MAX_STATEMENTS+1];

    assign accept = i_in_valid && o_in_ready;

    always_comb begin
        base         = i_new_program ? '0 : r_count;
        full         = (base >= FULL);
        in_stmt.ovf  = full;
        in_stmt.rset = i_read_set;
        in_stmt.wvar = i_write_var;
        in_pos       = full ? '0 : base[IDX_W-1:0];
        n_count      = r_count;
        if (accept) begin
            n_count = full ? base : base + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign w_valid[0] = i_in_valid;
    assign w_stmt[0]  = in_stmt;
    assign w_pos[0]   = in_pos;
    assign w_flow[0]  = '0;
    assign w_anti[0]  = '0;
    assign w_outd[0]  = '0;
    assign w_par[0]   = '0;
    assign w_move[MAX_STATEMENTS] = i_out_ready;
    assign o_in_ready = w_move[0];

    for (genvar j = 0; j < MAX_STATEMENTS; j++) begin : g_cell
        bdc_cell #(
            .MAX_STATEMENTS(MAX_STATEMENTS),
            .IDX           (j),
            .IDX_W         (IDX_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_valid    (w_valid[j]),
            .i_stmt     (w_stmt[j]),
            .i_pos      (w_pos[j]),
            .i_flow     (w_flow[j]),
            .i_anti     (w_anti[j]),
            .i_outd     (w_outd[j]),
            .i_par      (w_par[j]),
            .o_move     (w_move[j]),
            .i_down_move(w_move[j+1]),
            .o_valid    (w_valid[j+1]),
            .o_stmt     (w_stmt[j+1]),
            .o_pos      (w_pos[j+1]),
            .o_flow     (w_flow[j+1]),
            .o_anti     (w_anti[j+1]),
            .o_outd     (w_outd[j+1]),
            .o_par      (w_par[j+1])
        );
    end

    assign o_out_valid     = w_valid[MAX_STATEMENTS];
    assign o_stmt_position = POS_W'(w_pos[MAX_STATEMENTS]);
    assign o_flow_deps     = MASK_W'(w_flow[MAX_STATEMENTS]);
    assign o_anti_deps     = MASK_W'(w_anti[MAX_STATEMENTS]);
    assign o_output_deps   = MASK_W'(w_outd[MAX_STATEMENTS]);
    assign o_parallel_with = MASK_W'(w_par[MAX_STATEMENTS]);
    assign o_overflow      = w_stmt[MAX_STATEMENTS].ovf;

endmodule

`default_nettype wire

>>> tb/bdc_hazard_checker.sv
// Scoreboard for the Bernstein dependency checker: watches both channels,
// predicts every result word from its own statement history and compares.
// Depends on bdc_pkg for field widths.
module bdc_hazard_checker #(
    parameter int MAX_STATEMENTS = bdc_pkg::DEF_MAX_STATEMENTS
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    input  wire                          i_in_ready,
    input  wire                          i_new_program,
    input  wire [bdc_pkg::VAR_COUNT-1:0] i_read_set,
    input  wire [bdc_pkg::WVAR_W-1:0]    i_write_var,
    input  wire                          i_out_valid,
    input  wire                          i_out_ready,
    input  wire [bdc_pkg::POS_W-1:0]     i_stmt_position,
    input  wire [bdc_pkg::MASK_W-1:0]    i_flow_deps,
    input  wire [bdc_pkg::MASK_W-1:0]    i_anti_deps,
    input  wire [bdc_pkg::MASK_W-1:0]    i_output_deps,
    input  wire [bdc_pkg::MASK_W-1:0]    i_parallel_with,
    input  wire                          i_overflow,
    output int                           o_fail_count,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import bdc_pkg::*;

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [MASK_W-1:0] flow;
        logic [MASK_W-1:0] anti;
        logic [MASK_W-1:0] outd;
        logic [MASK_W-1:0] par;
        logic              ovf;
    } t_hazard;

    logic [VAR_COUNT-1:0] hist_rset [MAX_STATEMENTS];
    logic [WVAR_W-1:0]    hist_wvar [MAX_STATEMENTS];
    int                   hist_len;
    t_hazard              hazard_q [$];

    // Compare the new statement against the history, then append it.
    function automatic t_hazard predict_hazards(input logic np,
                                                input logic [VAR_COUNT-1:0] rs,
                                                input logic [WVAR_W-1:0] wv);
        t_hazard r;
        logic    f, a, o;
        r = '0;
        if (np)
            hist_len = 0;
        if (hist_len >= MAX_STATEMENTS) begin
            r.ovf = 1'b1;
            return r;
        end
        r.position = POS_W'(hist_len);
        for (int i = 0; i < hist_len; i++) begin
            // an index beyond Z is never named by a read mask
            f = (hist_wvar[i] < VAR_COUNT) ? rs[hist_wvar[i]] : 1'b0;
            a = (wv < VAR_COUNT) ? hist_rset[i][wv] : 1'b0;
            o = (hist_wvar[i] == wv);
            if (i < MASK_W) begin
                r.flow[i] = f;
                r.anti[i] = a;
                r.outd[i] = o;
                r.par[i]  = !(f || a || o);
            end
        end
        hist_rset[hist_len] = rs;
        hist_wvar[hist_len] = wv;
        hist_len++;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_hazard exp_w;
        t_hazard act_w;
        int      fails;
        fails = o_fail_count;
        if (!i_rst_n) begin
            hazard_q.delete();
            hist_len = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                act_w = {i_stmt_position, i_flow_deps, i_anti_deps, i_output_deps,
                         i_parallel_with, i_overflow};
                if (hazard_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: result word with nothing expected: pos=%0d ovf=%0b",
                                 $realtime, i_stmt_position, i_overflow);
                end else begin
                    exp_w = hazard_q.pop_front();
                    if (act_w.position !== exp_w.position || act_w.flow !== exp_w.flow ||
                        act_w.anti !== exp_w.anti || act_w.outd !== exp_w.outd ||
                        act_w.par !== exp_w.par || act_w.ovf !== exp_w.ovf) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("%0t: mismatch", $realtime);
                            $display("  exp pos=%0d flow=%h anti=%h out=%h par=%h ovf=%0b",
                                     exp_w.position, exp_w.flow, exp_w.anti, exp_w.outd,
                                     exp_w.par, exp_w.ovf);
                            $display("  got pos=%0d flow=%h anti=%h out=%h par=%h ovf=%0b",
                                     act_w.position, act_w.flow, act_w.anti, act_w.outd,
                                     act_w.par, act_w.ovf);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                hazard_q.insert(hazard_q.size(),
                                predict_hazards(i_new_program, i_read_set, i_write_var));
        end
        o_fail_count <= fails;
        o_pending    <= hazard_q.size();
    end

endmodule

>>> tb/tb_bernstein_dependency_checker.sv
// Testbench top for the Bernstein dependency checker: clock, reset, statement
// stimulus and output back-pressure. Depends on bdc_pkg, the block and
// bdc_hazard_checker, which does all prediction and comparison.
module tb_bernstein_dependency_checker;
    timeunit 1ns;
    timeprecision 1ps;

    import bdc_pkg::*;

    localparam int MAX_ST       = DEF_MAX_STATEMENTS;
    localparam int IDLE_PCT     = 34;
    localparam int RANDOM_WORDS = 950;
    localparam int QUIET_FROM   = 600;
    localparam int QUIET_TO     = 750;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_LEN     = 300;
    localparam int STUCK_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = MAX_ST + 8;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_in_valid    = 1'b0;
    logic                 i_new_program = 1'b0;
    logic [VAR_COUNT-1:0] i_read_set    = '0;
    logic [WVAR_W-1:0]    i_write_var   = '0;
    logic                 i_out_ready   = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [POS_W-1:0]     o_stmt_position;
    logic [MASK_W-1:0]    o_flow_deps;
    logic [MASK_W-1:0]    o_anti_deps;
    logic [MASK_W-1:0]    o_output_deps;
    logic [MASK_W-1:0]    o_parallel_with;
    logic                 o_overflow;
    int                   fail_count;
    int                   pending_words;
    int                   sent_words = 0;
    int                   stuck_cycles = 0;

    always #2 i_clk = ~i_clk;

    bernstein_dependency_checker #(.MAX_STATEMENTS(MAX_ST)) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_new_program   (i_new_program),
        .i_read_set      (i_read_set),
        .i_write_var     (i_write_var),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_stmt_position (o_stmt_position),
        .o_flow_deps     (o_flow_deps),
        .o_anti_deps     (o_anti_deps),
        .o_output_deps   (o_output_deps),
        .o_parallel_with (o_parallel_with),
        .o_overflow      (o_overflow)
    );

    bdc_hazard_checker #(.MAX_STATEMENTS(MAX_ST)) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_new_program   (i_new_program),
        .i_read_set      (i_read_set),
        .i_write_var     (i_write_var),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_stmt_position (o_stmt_position),
        .i_flow_deps     (o_flow_deps),
        .i_anti_deps     (o_anti_deps),
        .i_output_deps   (o_output_deps),
        .i_parallel_with (o_parallel_with),
        .i_overflow      (o_overflow),
        .o_fail_count    (fail_count),
        .o_pending       (pending_words)
    );

    function automatic bit quiet_phase();
        return sent_words >= QUIET_FROM && sent_words < QUIET_TO;
    endfunction

    // Offer one statement word after a random gap, none in the quiet phase, and hold it until taken.
    task automatic send_word(input logic np, input logic [VAR_COUNT-1:0] rs,
                             input logic [WVAR_W-1:0] wv);
        while (!quiet_phase() && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_new_program <= np;
        i_read_set    <= rs;
        i_write_var   <= wv;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        sent_words++;
    endtask

    // Read sets drawn around a small pool of variables so hazards are common.
    function automatic logic [VAR_COUNT-1:0] pick_read_set(input int lo);
        logic [VAR_COUNT-1:0] pool;
        pool = VAR_COUNT'(4'hF) << lo;
        case ($urandom_range(0, 3))
            0: return VAR_COUNT'($urandom);
            1: return VAR_COUNT'(1) << (lo + $urandom_range(0, 3));
            2: return $urandom_range(0, 1) ? '1 : '0;
            default: return pool & VAR_COUNT'($urandom);
        endcase
    endfunction

    function automatic logic [WVAR_W-1:0] pick_write_var(input int lo);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 85)
            return WVAR_W'(lo + $urandom_range(0, 3));
        else if (roll < 95)
            return WVAR_W'($urandom_range(0, VAR_COUNT - 1));
        else
            return WVAR_W'($urandom_range(VAR_COUNT, 31));
    endfunction

    // Output side: random back-pressure, one long hold-off, one quiet stretch.
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!hold_done && sent_words >= HOLD_AT) begin
                hold_left = HOLD_LEN;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (quiet_phase()) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        int plen;
        int lo;
        int rnd_count;
        logic np;
        rnd_count = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, index beyond Z, table fill, overflow, clear
        send_word(1'b1, '0, '0);
        send_word(1'b0, '1, WVAR_W'(VAR_COUNT - 1));
        send_word(1'b0, VAR_COUNT'(1) << (VAR_COUNT - 1), '0);
        send_word(1'b0, '1, '1);
        send_word(1'b0, '0, '1);
        send_word(1'b0, '0, WVAR_W'(VAR_COUNT));
        for (int i = 6; i < MAX_ST; i++)
            send_word(1'b0, VAR_COUNT'(1) << i, WVAR_W'(i));
        send_word(1'b0, '1, '1);
        send_word(1'b0, '0, '0);
        send_word(1'b0, VAR_COUNT'($urandom), WVAR_W'(VAR_COUNT - 1));
        send_word(1'b1, '1, WVAR_W'(VAR_COUNT - 1));
        send_word(1'b1, '0, WVAR_W'(5));
        send_word(1'b0, '1, WVAR_W'(5));

        // random programs, mostly well formed, some running past the table
        while (rnd_count < RANDOM_WORDS) begin
            plen = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_ST + 1, MAX_ST + 6)
                                               : $urandom_range(1, MAX_ST);
            lo = $urandom_range(0, VAR_COUNT - 4);
            for (int k = 0; k < plen; k++) begin
                np = (k == 0);
                if ($urandom_range(0, 19) == 0)
                    np = $urandom_range(0, 1);
                send_word(np, pick_read_set(lo), pick_write_var(lo));
                rnd_count++;
            end
        end
        i_in_valid <= 1'b0;

        // drain: the pending count is registered, so it lags behind the checker
        @(posedge i_clk);
        while (pending_words != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
